>>> rtl/sse_pkg.sv
// Shared constants, types and helpers for the sorted set engine.
// Depends on nothing; imported by every module of the engine.
package sse_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 32;
   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   localparam int CMD_BITS    = 2;
   localparam int IN_KEY_BITS = 32;
   localparam int POS_BITS    = 6;
   localparam int STAT_BITS   = 2;
   localparam int ELEM_BITS   = 32;
   localparam int COUNT_BITS  = 7;

   localparam int REQ_BITS = 40;
   localparam int RSP_BITS = 48;

   localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FIND   = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_GET    = 2'd3;

   localparam logic [STAT_BITS-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_BITS-1:0] ST_NOKEY  = 2'd1;
   localparam logic [STAT_BITS-1:0] ST_FULL   = 2'd2;
   localparam logic [STAT_BITS-1:0] ST_RANGE  = 2'd3;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   // Control word broadcast to every cell.
   typedef struct packed {
      logic cmp_en;
      logic add_en;
      logic rem_en;
   } cell_ctl_type;

   function automatic key_type to_key(input logic [IN_KEY_BITS-1:0] k);
      to_key = KEY_BITS'(k);
   endfunction

endpackage

>>> rtl/sse_cell.sv
// One slot of the sorted key chain: holds a key, compares it against the
// command key and shifts toward its neighbors. Depends on sse_pkg.
module sse_cell import sse_pkg::*; (
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic [IDX_BITS-1:0] cell_idx,
   input  cnt_type             count,
   input  key_type             cmp_key,
   input  logic [POS_BITS-1:0] cmp_pos,
   input  key_type             ins_key,
   input  key_type             left_key,
   input  logic                left_lt,
   input  key_type             right_key,
   output key_type             key_q,
   output logic                lt_q,
   output logic                eq_q,
   output logic                sel_q
);

   key_type key_ff, key_in;
   logic    lt_ff, eq_ff, sel_ff;
   logic    vld;

   assign vld = 32'(cell_idx) < 32'(count);

   always_comb begin
      key_in = key_ff;
      if (ctl.add_en && !lt_ff) begin
         // lower neighbor below the new key: this is the insert slot
         key_in = left_lt ? ins_key : left_key;
      end else if (ctl.rem_en && !lt_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (ctl.cmp_en) begin
         lt_ff  <= vld && (key_ff < cmp_key);
         eq_ff  <= vld && (key_ff == cmp_key);
         sel_ff <= vld && (32'(cell_idx) == 32'(cmp_pos));
      end
   end

   assign key_q = key_ff;
   assign lt_q  = lt_ff;
   assign eq_q  = eq_ff;
   assign sel_q = sel_ff;

endmodule

>>> rtl/sse_chain.sv
// Row of CAPACITY key cells wired as a shift chain, plus the OR trees
// that gather presence and the selected key. Depends on sse_pkg, sse_cell.
module sse_chain import sse_pkg::*; (
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  cnt_type             count,
   input  key_type             cmp_key,
   input  logic [POS_BITS-1:0] cmp_pos,
   input  key_type             ins_key,
   output logic                present,
   output key_type             sel_key
);

   key_type           keys [CAPACITY];
   logic [CAPACITY-1:0] lt, eq, sel;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type left_key, right_key;
      logic    left_lt;

      if (i == 0) begin : g_first
         assign left_key = keys[i];
         assign left_lt  = 1'b1;
      end else begin : g_mid
         assign left_key = keys[i-1];
         assign left_lt  = lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = keys[i];
      end else begin : g_inner
         assign right_key = keys[i+1];
      end

      sse_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .cell_idx  (IDX_BITS'(i)),
         .count     (count),
         .cmp_key   (cmp_key),
         .cmp_pos   (cmp_pos),
         .ins_key   (ins_key),
         .left_key  (left_key),
         .left_lt   (left_lt),
         .right_key (right_key),
         .key_q     (keys[i]),
         .lt_q      (lt[i]),
         .eq_q      (eq[i]),
         .sel_q     (sel[i])
      );
   end

   assign present = |eq;

   always_comb begin
      sel_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_key = sel_key | (keys[i] & {KEY_BITS{sel[i]}});
      end
   end

endmodule

>>> rtl/sorted_set_engine.sv
// Sorted set engine: ascending key store built as a chain of compare/shift cells.
// Flow: a new command word is accepted only in idle; all cells then register their
// compares, and the apply step shifts the chain and writes the result word; a
// stalled result word holds the next apply step.
// Reset: synchronous, active high; clears count and handshake state, cells keep
// their keys, which are unused until written.
module sorted_set_engine import sse_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [1:0] cmd, [33:2] key, [39:34] position
   input  logic [REQ_BITS-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [1:0] status, [2] found, [34:3] element, [41:35] count, [47:42] zero
   output logic [RSP_BITS-1:0] rsp_tdata
);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_APPLY = 1'b1;

   logic                  state_ff, state_in;
   cnt_type               count_ff, count_in;
   logic [CMD_BITS-1:0]   cmd_ff;
   logic [POS_BITS-1:0]   pos_ff;
   key_type               key_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic                  req_fire, apply;
   cell_ctl_type          ctl;
   logic                  present;
   key_type               sel_key;
   logic [STAT_BITS-1:0]  status;
   logic                  found;
   logic [ELEM_BITS-1:0]  element;
   logic                  in_range;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // apply once the output register is free or being drained
   assign apply      = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign in_range   = 32'(pos_ff) < 32'(count_ff);

   // Decide the result and the chain operation from the registered compares.
   always_comb begin
      status     = ST_OK;
      found      = 1'b0;
      element    = '0;
      count_in   = count_ff;
      ctl.cmp_en = req_fire;
      ctl.add_en = 1'b0;
      ctl.rem_en = 1'b0;
      case (cmd_ff)
         CMD_ADD: begin
            if (present) begin
               status = ST_NOKEY;
            end else if (32'(count_ff) >= CAPACITY) begin
               status = ST_FULL;
            end else begin
               ctl.add_en = apply;
               count_in   = count_ff + cnt_type'(1);
            end
         end
         CMD_REMOVE: begin
            if (!present) begin
               status = ST_NOKEY;
            end else begin
               ctl.rem_en = apply;
               count_in   = count_ff - cnt_type'(1);
            end
         end
         CMD_FIND: begin
            found = present;
         end
         CMD_GET: begin
            if (in_range) begin
               element = ELEM_BITS'(sel_key);
            end else begin
               status = ST_RANGE;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   sse_chain u_chain (
      .clock   (clock),
      .ctl     (ctl),
      .count   (count_ff),
      .cmp_key (to_key(req_tdata[33:2])),
      .cmp_pos (req_tdata[39:34]),
      .ins_key (key_ff),
      .present (present),
      .sel_key (sel_key)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         state_in = S_APPLY;
      end
      if (apply) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, COUNT_BITS'(count_in), element, found, status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply) begin
            count_ff <= count_in;
         end
      end
   end

   // Hold command fields and the result word; no reset needed.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         cmd_ff <= req_tdata[1:0];
         key_ff <= to_key(req_tdata[33:2]);
         pos_ff <= req_tdata[39:34];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("count exceeds capacity");

   a_fire_to_apply: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_APPLY)
      else $error("accepted command did not enter apply");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_APPLY))
      else $error("result word without apply step");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(apply))
      else $error("count changed outside apply");

endmodule
